// ===== rtl/sqwb_pkg.sv =====
`timescale 1ns / 1ps

package sqwb_pkg;

  // field widths
  localparam int unsigned IdxW    = 4;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned CountW  = 16;

  localparam logic [CountW-1:0] BurstTicksReset = 16'd20000;

  // item codes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } opcode_e;

  // burst sequencer, one-hot
  typedef enum logic [2:0] {
    ST_INIT = 3'b001,
    ST_IDLE = 3'b010,
    ST_TX   = 3'b100
  } state_e;

  // period table write request
  typedef struct packed {
    logic               en;
    logic [IdxW-1:0]    idx;
    logic [PeriodW-1:0] period;
  } tbl_wr_t;

endpackage

// ===== rtl/sqwb_table.sv =====
`timescale 1ns / 1ps

module sqwb_table #(
  parameter int unsigned NumFrequencies = 16
) (
  input  logic                              clk_i,
  input  sqwb_pkg::tbl_wr_t                 wr_i,
  input  logic [sqwb_pkg::IdxW-1:0]         rd_idx_i,
  output logic [sqwb_pkg::PeriodW-1:0]      threshold_o
);
  import sqwb_pkg::*;

  // a 4-bit select never reaches past sixteen entries
  localparam int unsigned TableDepth = (NumFrequencies < 16) ? NumFrequencies : 16;
  localparam int unsigned AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned Entries    = 2 ** AddrW;

  logic [PeriodW-1:0] mem_q [Entries];
  logic               wr_in_range;
  logic               rd_in_range;
  logic [PeriodW-1:0] period_rd;

  assign wr_in_range = {3'b000, wr_i.idx} < 7'(NumFrequencies);
  assign rd_in_range = {3'b000, rd_idx_i} < 7'(NumFrequencies);

  // table write, out-of-range indexes dropped
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_in_range) begin
      mem_q[wr_i.idx[AddrW-1:0]] <= wr_i.period;
    end
  end

  // read for the latched select, absent entries read as zero
  always_comb begin
    period_rd = '0;
    if (rd_in_range) begin
      period_rd = mem_q[rd_idx_i[AddrW-1:0]];
    end
  end

  // half-period threshold, saturates at zero
  assign threshold_o = (period_rd < 16'd2) ? '0 : ((period_rd >> 1) - 16'd1);

endmodule

// ===== rtl/square_wave_burst_generator.sv =====
`timescale 1ns / 1ps
// channel  | handshake                  | word
// ---------+----------------------------+----------------------------------------------
// input    | in_valid_i / in_ready_o    | opcode, table index/period, start, cont, freq
// output   | out_valid_o / out_ready_i  | pin_level, running, active_frequency
// config   | cfg_we_i (no wait)         | cfg_wdata_i = burst_ticks
//
// one word per clock unless the output stalls: the state update for a word is one
// compare-and-count step ahead of the result register, valid the cycle after accept.
// rst_ni clears the sequencer, counters and burst_ticks (20000); table contents are
// undefined until loaded. a stalled output blocks new input only while the
// result register is full and not being taken.

module square_wave_burst_generator #(
  parameter int unsigned NUM_FREQUENCIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [sqwb_pkg::CountW-1:0]       cfg_wdata_i,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [sqwb_pkg::IdxW-1:0]         table_index_i,
  input  logic [sqwb_pkg::PeriodW-1:0]      table_period_i,
  input  logic                              start_request_i,
  input  logic                              continuous_i,
  input  logic [sqwb_pkg::IdxW-1:0]         next_frequency_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              pin_level_o,
  output logic                              running_o,
  output logic [sqwb_pkg::IdxW-1:0]         active_frequency_o
);
  import sqwb_pkg::*;

  logic               accept;
  tbl_wr_t            tbl_wr;
  logic [PeriodW-1:0] threshold;

  state_e             state_q, state_d;
  logic               running_q, running_d;
  logic [IdxW-1:0]    freq_q, freq_d;
  logic [CountW-1:0]  half_cnt_q, half_cnt_d;
  logic [CountW-1:0]  burst_cnt_q, burst_cnt_d;
  logic               level_q, level_d;
  logic [CountW-1:0]  burst_ticks_q;
  logic               out_valid_q;
  logic               pin_q, run_out_q;
  logic [IdxW-1:0]    freq_out_q;
  logic               burst_done;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // period table
  assign tbl_wr.en     = accept && (opcode_e'(opcode_i) == OP_LOAD);
  assign tbl_wr.idx    = table_index_i;
  assign tbl_wr.period = table_period_i;

  sqwb_table #(
    .NumFrequencies(NUM_FREQUENCIES)
  ) u_table (
    .clk_i      (clk_i),
    .wr_i       (tbl_wr),
    .rd_idx_i   (freq_q),
    .threshold_o(threshold)
  );

  assign burst_done = burst_cnt_q >= burst_ticks_q;

  // tick step
  always_comb begin
    state_d     = state_q;
    running_d   = running_q;
    freq_d      = freq_q;
    half_cnt_d  = half_cnt_q;
    burst_cnt_d = burst_cnt_q;
    level_d     = level_q;
    if (opcode_e'(opcode_i) == OP_TICK) begin
      if (start_request_i) begin
        running_d = 1'b1;
      end
      case (state_q)
        ST_INIT: begin
          state_d = ST_IDLE;
        end
        ST_IDLE: begin
          if (running_d) begin
            state_d     = ST_TX;
            freq_d      = next_frequency_i;
            half_cnt_d  = '0;
            burst_cnt_d = '0;
            level_d     = 1'b0;
          end
        end
        ST_TX: begin
          if (burst_done && !continuous_i) begin
            state_d     = ST_IDLE;
            running_d   = 1'b0;
            burst_cnt_d = '0;
            half_cnt_d  = '0;
            level_d     = 1'b0;
          end else if (burst_done) begin
            freq_d      = next_frequency_i;
            half_cnt_d  = '0;
            burst_cnt_d = '0;
            level_d     = 1'b0;
          end else if (half_cnt_q >= threshold) begin
            level_d     = !level_q;
            burst_cnt_d = burst_cnt_q + 16'd1;
            half_cnt_d  = '0;
          end else begin
            burst_cnt_d = burst_cnt_q + 16'd1;
            half_cnt_d  = half_cnt_q + 16'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer state and config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_INIT;
      running_q     <= 1'b0;
      freq_q        <= '0;
      half_cnt_q    <= '0;
      burst_cnt_q   <= '0;
      level_q       <= 1'b0;
      burst_ticks_q <= BurstTicksReset;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        running_q   <= running_d;
        freq_q      <= freq_d;
        half_cnt_q  <= half_cnt_d;
        burst_cnt_q <= burst_cnt_d;
        level_q     <= level_d;
      end
      if (cfg_we_i) begin
        burst_ticks_q <= cfg_wdata_i;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pin_q      <= level_d;
      run_out_q  <= running_d;
      freq_out_q <= freq_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pin_level_o        = pin_q;
  assign running_o          = run_out_q;
  assign active_frequency_o = freq_out_q;

endmodule

// ===== rtl/sqwb_checker.sv =====
`timescale 1ns / 1ps

module sqwb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         pin_level_o,
  input logic                         running_o,
  input logic [sqwb_pkg::IdxW-1:0]    active_frequency_o
);
  import sqwb_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pin_level_o)
      && $stable(running_o) && $stable(active_frequency_o))
    else $error("result word changed while stalled");

  // every accepted word yields a result next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted word produced no result");

  // empty result register never blocks input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty result register");

  // pin is only high during a burst
  a_pin_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pin_level_o |-> running_o)
    else $error("pin high while not running");

endmodule

bind square_wave_burst_generator sqwb_checker u_sqwb_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .pin_level_o       (pin_level_o),
  .running_o         (running_o),
  .active_frequency_o(active_frequency_o)
);
